// ----- rtl/srl_pkg.sv -----
// package for the sorted record list: sizes, command and status codes,
// record and shift-control types shared by the cell row and the top level
// no dependencies
`timescale 1ns / 1ps

package srl_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int CMD_W    = 3;
    localparam int INDEX_W  = 6;
    localparam int KEY_W    = 32;
    localparam int PRICE_W  = 32;
    localparam int TAG_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;
    localparam int POS_W    = 5;

    localparam int IN_BITS  = CMD_W + INDEX_W + KEY_W + PRICE_W + TAG_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = STATUS_W + COUNT_W + POS_W + KEY_W + PRICE_W + TAG_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_SORT_INS = 3'd0,
        CMD_DEL_KEY  = 3'd1,
        CMD_INS_IDX  = 3'd2,
        CMD_DEL_IDX  = 3'd3,
        CMD_READ     = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PRICE_W-1:0]      price;
        logic [TAG_W-1:0]        tag;
    } t_rec;

    // broadcast to every cell when a command is applied
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] pos;
    } t_shift;

endpackage

// ----- rtl/srl_cell.sv -----
// one slot of the record row: holds a record, compares its key against the
// probe key and shifts to or from its neighbours; uses srl_pkg
`timescale 1ns / 1ps

module srl_cell (
    input  logic                          i_clk,
    input  logic [srl_pkg::IDX_W-1:0]     i_index,
    input  srl_pkg::t_shift               i_op,
    input  srl_pkg::t_rec                 i_new,
    input  srl_pkg::t_rec                 i_prev,
    input  srl_pkg::t_rec                 i_next,
    input  logic signed [srl_pkg::KEY_W-1:0] i_probe_key,
    output srl_pkg::t_rec                 o_rec,
    output logic                          o_gt,
    output logic                          o_eq
);
    import srl_pkg::*;

    t_rec r_rec;
    t_rec n_rec;

    always_comb begin
        n_rec = r_rec;
        if (i_op.ins) begin
            if (i_index == i_op.pos) begin
                n_rec = i_new;
            end else if (i_index > i_op.pos) begin
                n_rec = i_prev;
            end
        end else if (i_op.del) begin
            if (i_index >= i_op.pos) begin
                n_rec = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec = r_rec;
    assign o_gt  = (r_rec.key > i_probe_key);
    assign o_eq  = (r_rec.key == i_probe_key);

endmodule

// ----- rtl/sorted_record_list_unit.sv -----
// sorted record list: one transaction in, one result out; each transaction
// steps through compare in every cell, isolate the first hit, then apply the
// shift across the cell row and register the result
// a new transaction is taken only in idle, once the previous result has been registered;
// the apply step waits while the output still holds an untaken result
// reset clears the record count and the handshake state; slot contents are never read unwritten
`timescale 1ns / 1ps

module sorted_record_list_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // command, index, key, price_bits, record_tag, zero pad
    input  logic [srl_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // status, count, position, key_out, price_out, tag_out, zero pad
    output logic [srl_pkg::OUT_W-1:0]   m_axis_tdata
);
    import srl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_LOC  = 4'b0100,
        S_EXEC = 4'b1000
    } t_state;

    localparam int IDX_LO   = CMD_W;
    localparam int KEY_LO   = IDX_LO + INDEX_W;
    localparam int PRICE_LO = KEY_LO + KEY_W;
    localparam int TAG_LO   = PRICE_LO + PRICE_W;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;

    t_cmd               r_cmd;
    logic [INDEX_W-1:0] r_idx;
    t_rec               r_in;

    logic [CAPACITY-1:0] r_flags;
    logic [CAPACITY-1:0] r_first;
    logic                r_any;

    logic            r_out_valid;
    t_status         r_out_status;
    logic [COUNT_W-1:0] r_out_count;
    logic [POS_W-1:0]   r_out_pos;
    t_rec            r_out_rec;

    t_rec            w_rec [CAPACITY];
    logic [CAPACITY-1:0] w_gt;
    logic [CAPACITY-1:0] w_eq;
    t_shift          w_op;
    logic [IDX_W-1:0] w_first_pos;
    logic            w_out_free;
    logic            w_accept;
    logic            w_apply;
    t_status         w_status;
    logic [IDX_W-1:0] w_pos;
    t_rec            w_read;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_apply    = (r_state == S_EXEC) && w_out_free;
    assign s_axis_tready = (r_state == S_IDLE);

    // cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_rec w_prev;
        t_rec w_next;
        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid
            assign w_prev = w_rec[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_next = w_rec[g];
        end else begin : g_inner
            assign w_next = w_rec[g+1];
        end
        srl_cell u_cell (
            .i_clk       (i_clk),
            .i_index     (IDX_W'(g)),
            .i_op        (w_op),
            .i_new       (r_in),
            .i_prev      (w_prev),
            .i_next      (w_next),
            .i_probe_key (r_in.key),
            .o_rec       (w_rec[g]),
            .o_gt        (w_gt[g]),
            .o_eq        (w_eq[g])
        );
    end

    // one-hot of the first hit to a slot number
    always_comb begin
        w_first_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (r_first[i]) begin
                w_first_pos = w_first_pos | IDX_W'(i);
            end
        end
    end

    assign w_read = w_rec[r_idx[IDX_W-1:0]];

    always_comb begin
        w_status = ST_OK;
        w_pos    = '0;
        w_op     = '{ins: 1'b0, del: 1'b0, pos: '0};
        n_count  = r_count;
        case (r_cmd)
            CMD_SORT_INS: begin
                if (r_count == CNT_W'(CAPACITY)) begin
                    w_status = ST_FULL;
                end else begin
                    w_pos = r_any ? w_first_pos : r_count[IDX_W-1:0];
                end
            end
            CMD_INS_IDX: begin
                if (r_count == CNT_W'(CAPACITY)) begin
                    w_status = ST_FULL;
                end else if (r_idx > INDEX_W'(r_count)) begin
                    w_status = ST_BAD_INDEX;
                end else begin
                    w_pos = r_idx[IDX_W-1:0];
                end
            end
            CMD_DEL_KEY: begin
                if (!r_any) begin
                    w_status = ST_NOT_FOUND;
                end else begin
                    w_pos = w_first_pos;
                end
            end
            CMD_DEL_IDX, CMD_READ: begin
                if (r_idx >= INDEX_W'(r_count)) begin
                    w_status = ST_BAD_INDEX;
                end else begin
                    w_pos = r_idx[IDX_W-1:0];
                end
            end
            default: begin
                w_status = ST_BAD_INDEX;
            end
        endcase
        if (w_apply && w_status == ST_OK) begin
            w_op.pos = w_pos;
            if (r_cmd == CMD_SORT_INS || r_cmd == CMD_INS_IDX) begin
                w_op.ins = 1'b1;
                n_count  = r_count + 1'b1;
            end else if (r_cmd == CMD_DEL_KEY || r_cmd == CMD_DEL_IDX) begin
                w_op.del = 1'b1;
                n_count  = r_count - 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_CMP;
            S_CMP:   n_state = S_LOC;
            S_LOC:   n_state = S_EXEC;
            S_EXEC:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_apply) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= t_cmd'(s_axis_tdata[CMD_W-1:0]);
            r_idx  <= s_axis_tdata[KEY_LO-1:IDX_LO];
            r_in.key   <= s_axis_tdata[PRICE_LO-1:KEY_LO];
            r_in.price <= s_axis_tdata[TAG_LO-1:PRICE_LO];
            r_in.tag   <= s_axis_tdata[TAG_LO+TAG_W-1:TAG_LO];
        end
        if (r_state == S_CMP) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_flags[i] <= (CNT_W'(i) < r_count) &&
                              ((r_cmd == CMD_SORT_INS) ? w_gt[i] : w_eq[i]);
            end
        end
        if (r_state == S_LOC) begin
            // isolate the lowest set flag
            r_first <= r_flags & (~r_flags + 1'b1);
            r_any   <= |r_flags;
        end
        if (w_apply) begin
            r_out_status <= w_status;
            r_out_count  <= COUNT_W'(n_count);
            r_out_pos    <= (w_status == ST_OK) ? POS_W'(w_pos) : '0;
            r_out_rec    <= (r_cmd == CMD_READ && w_status == ST_OK) ? w_read : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_rec.tag, r_out_rec.price, r_out_rec.key,
                                   r_out_pos, r_out_count, r_out_status});

endmodule

// ----- test/tb_sorted_record_list_unit.sv -----
// self-checking bench for sorted_record_list_unit: a queued driver, a monitor that
// predicts every result from its own copy of the list, then field-by-field checks
// depends on srl_pkg and the rtl top level only
`timescale 1ns / 1ps

module tb_sorted_record_list_unit;

    import srl_pkg::*;

    localparam int TOTAL_ITEMS     = 1550;
    localparam int FIRST_SPARE_CMD = 5;
    localparam int LAST_SPARE_CMD  = 7;
    localparam int DRAIN_CYCLES    = 20;
    localparam int FULL_RETRIES    = 3;

    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

    // fields from the lowest bit up: command, index, key, price, tag
    typedef struct packed {
        logic [TAG_W-1:0]        tag;
        logic [PRICE_W-1:0]      price;
        logic signed [KEY_W-1:0] key;
        logic [INDEX_W-1:0]      index;
        logic [CMD_W-1:0]        cmd;
    } t_cmd_word;

    // fields from the lowest bit up: status, count, position, key, price, tag
    typedef struct packed {
        logic [TAG_W-1:0]   tag_out;
        logic [PRICE_W-1:0] price_out;
        logic [KEY_W-1:0]   key_out;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
        t_status            status;
    } t_answer;

    typedef struct packed {
        logic      hold;    // wait for every outstanding result before sending
        t_cmd_word word;
    } t_job;

    typedef struct packed {
        logic [CNT_W-1:0]      count;
        t_rec [CAPACITY-1:0]   slots;
    } t_shelf;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;

    t_job    pending[$];
    t_answer expected_answers[$];
    t_shelf  plan_shelf;
    t_shelf  model_shelf;
    logic    in_taken = 1'b0;
    int      n_accepted = 0;
    int      n_mismatch = 0;
    int      n_by_cmd[8];
    int      n_by_status[4];
    int      peak_count = 0;
    int      tx_idle_pct;
    int      rx_idle_pct;

    sorted_record_list_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // applies one command to a list image and gives the answer it produces
    function automatic t_answer shelf_apply(input t_shelf cur, input t_cmd_word w,
                                            output t_shelf nxt);
        t_answer a;
        int n, pos, i;
        a = '0;
        nxt = cur;
        n = int'(cur.count);
        pos = 0;
        a.status = ST_OK;
        case (w.cmd)
            CMD_SORT_INS, CMD_INS_IDX: begin
                if (n >= CAPACITY) begin
                    a.status = ST_FULL;
                end else if (w.cmd == CMD_INS_IDX && int'(w.index) > n) begin
                    a.status = ST_BAD_INDEX;
                end else begin
                    if (w.cmd == CMD_INS_IDX) begin
                        pos = int'(w.index);
                    end else begin
                        // first entry with a greater key, so equal keys keep arrival order
                        pos = n;
                        for (i = n - 1; i >= 0; i--)
                            if ($signed(cur.slots[i].key) > $signed(w.key)) pos = i;
                    end
                    for (i = n; i > pos; i--) nxt.slots[i] = cur.slots[i - 1];
                    nxt.slots[pos] = '{key: w.key, price: w.price, tag: w.tag};
                    nxt.count = cur.count + 1'b1;
                end
            end
            CMD_DEL_KEY, CMD_DEL_IDX: begin
                if (w.cmd == CMD_DEL_KEY) begin
                    pos = -1;
                    for (i = n - 1; i >= 0; i--)
                        if (cur.slots[i].key == w.key) pos = i;
                    if (pos < 0) a.status = ST_NOT_FOUND;
                end else if (int'(w.index) >= n) begin
                    a.status = ST_BAD_INDEX;
                end else begin
                    pos = int'(w.index);
                end
                if (a.status == ST_OK) begin
                    for (i = pos; i < n - 1; i++) nxt.slots[i] = cur.slots[i + 1];
                    nxt.count = cur.count - 1'b1;
                end
            end
            CMD_READ: begin
                if (int'(w.index) >= n) begin
                    a.status = ST_BAD_INDEX;
                end else begin
                    pos = int'(w.index);
                    a.key_out   = cur.slots[pos].key;
                    a.price_out = cur.slots[pos].price;
                    a.tag_out   = cur.slots[pos].tag;
                end
            end
            default: a.status = ST_BAD_INDEX;
        endcase
        if (a.status != ST_OK) pos = 0;
        a.count = nxt.count;
        a.position = POS_W'(pos);
        return a;
    endfunction

    // small keys collide often, which exercises equal-key ordering and key deletes
    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35) return 32'($urandom_range(8, 0)) - 32'd4;
        if (roll < 50) begin
            case ($urandom_range(3))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int index,
                             input logic [KEY_W-1:0] key, input logic [PRICE_W-1:0] price,
                             input logic [TAG_W-1:0] tag, input logic hold);
        t_job j;
        t_shelf nx;
        t_answer ignored;
        j.hold = hold;
        j.word.cmd = cmd;
        j.word.index = INDEX_W'(index);
        j.word.key = key;
        j.word.price = price;
        j.word.tag = tag;
        ignored = shelf_apply(plan_shelf, j.word, nx);
        plan_shelf = nx;
        pending.push_back(j);
    endtask

    task automatic compare_field(input string fname, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", fname, want, got);
            n_mismatch++;
        end
    endtask

    // driver: new transactions only once the previous one has been taken
    always @(negedge i_clk) begin
        if (n_accepted < TOTAL_ITEMS / 3) begin
            tx_idle_pct = 24;
            rx_idle_pct = 71;
        end else if (n_accepted < 2 * TOTAL_ITEMS / 3) begin
            tx_idle_pct = 71;
            rx_idle_pct = 24;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            if (!s_axis_tvalid || in_taken) begin
                if (pending.size() != 0
                    && !(pending[0].hold && expected_answers.size() != 0)
                    && $urandom_range(99) >= tx_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_W'(pending[0].word);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks results, predicts on every accepted command
    always @(posedge i_clk) begin
        t_answer got, want;
        t_job job;
        t_shelf nx;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_answer'(m_axis_tdata[OUT_BITS-1:0]);
                if (expected_answers.size() == 0) begin
                    $error("result transaction with no command outstanding: 0x%h",
                           m_axis_tdata);
                    n_mismatch++;
                end else begin
                    want = expected_answers.pop_front();
                    n_by_status[want.status]++;
                    compare_field("status", 32'(want.status), 32'(got.status));
                    compare_field("count", 32'(want.count), 32'(got.count));
                    compare_field("position", 32'(want.position), 32'(got.position));
                    compare_field("key_out", want.key_out, got.key_out);
                    compare_field("price_out", want.price_out, got.price_out);
                    compare_field("tag_out", want.tag_out, got.tag_out);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                in_taken = 1'b1;
                job = pending.pop_front();
                expected_answers.push_back(shelf_apply(model_shelf, job.word, nx));
                model_shelf = nx;
                n_by_cmd[job.word.cmd]++;
                n_accepted++;
                if (int'(model_shelf.count) > peak_count) peak_count = int'(model_shelf.count);
            end
        end
    end

    initial begin
        int n, roll, retries, pick;
        logic filling, hold;
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;

        plan_shelf = '0;
        model_shelf = '0;
        foreach (n_by_cmd[c]) n_by_cmd[c] = 0;
        foreach (n_by_status[s]) n_by_status[s] = 0;

        // directed: empty-list failures, extremes, equal keys, every command
        queue_cmd(CMD_READ,    0, '0, '0, '0, 1'b0);
        queue_cmd(CMD_DEL_KEY, 0, '0, '0, '0, 1'b0);
        queue_cmd(CMD_DEL_IDX, 0, '0, '0, '0, 1'b0);
        queue_cmd(CMD_INS_IDX, 1, 32'd9, 32'h1, 32'h2, 1'b0);
        queue_cmd(CMD_SORT_INS, 0, '0, '0, '0, 1'b0);
        queue_cmd(CMD_SORT_INS, 0, KEY_MAX, '1, '1, 1'b0);
        queue_cmd(CMD_SORT_INS, 0, KEY_MIN, 32'h7f80_0000, 32'haaaa_aaaa, 1'b0);
        queue_cmd(CMD_SORT_INS, 0, '0, 32'h3f80_0000, 32'h5555_5555, 1'b0);
        queue_cmd(CMD_INS_IDX, 0, 32'd5, 32'hc000_0000, 32'h1234_5678, 1'b0);
        queue_cmd(CMD_INS_IDX, int'(plan_shelf.count), '1, 32'hffc0_0000, 32'h0f0f_0f0f,
                  1'b0);
        queue_cmd(CMD_READ, 0, '0, '0, '0, 1'b0);
        queue_cmd(CMD_READ, int'(plan_shelf.count) - 1, '0, '0, '0, 1'b0);
        queue_cmd(CMD_READ, int'(plan_shelf.count), '0, '0, '0, 1'b0);
        queue_cmd(CMD_READ, 63, '1, '1, '1, 1'b0);
        for (int c = FIRST_SPARE_CMD; c <= LAST_SPARE_CMD; c++)
            queue_cmd(CMD_W'(c), 63, $urandom, $urandom, $urandom, 1'b0);
        queue_cmd(CMD_DEL_KEY, 0, KEY_MIN, '0, '0, 1'b0);
        queue_cmd(CMD_DEL_KEY, 0, 32'd12345, '0, '0, 1'b0);
        queue_cmd(CMD_DEL_KEY, 0, '0, '0, '0, 1'b0);
        queue_cmd(CMD_DEL_IDX, 0, '0, '0, '0, 1'b0);
        queue_cmd(CMD_DEL_IDX, int'(plan_shelf.count) - 1, '0, '0, '0, 1'b0);
        queue_cmd(CMD_DEL_IDX, 32, '0, '0, '0, 1'b0);
        queue_cmd(CMD_READ, 0, '0, '0, '0, 1'b0);

        // random: alternate fill and drain sweeps so the full and empty edges recur
        filling = 1'b1;
        retries = 0;
        hold = 1'b1;
        while (pending.size() < TOTAL_ITEMS) begin
            n = int'(plan_shelf.count);
            if (pending.size() == TOTAL_ITEMS / 2) hold = 1'b1;
            if (filling && n == CAPACITY) begin
                if (retries++ >= FULL_RETRIES) begin
                    filling = 1'b0;
                    retries = 0;
                end
            end else if (!filling && n == 0) begin
                if (retries++ >= FULL_RETRIES) begin
                    filling = 1'b1;
                    retries = 0;
                end
            end
            roll = $urandom_range(99);
            if (filling && n == CAPACITY)
                roll = $urandom_range(69);
            if (filling) begin
                if (roll < 50)      cmd = CMD_SORT_INS;
                else if (roll < 70) cmd = CMD_INS_IDX;
                else if (roll < 85) cmd = CMD_READ;
                else if (roll < 95) cmd = roll[0] ? CMD_DEL_KEY : CMD_DEL_IDX;
                else                cmd = CMD_W'($urandom_range(LAST_SPARE_CMD));
            end else begin
                if (roll < 30)      cmd = CMD_DEL_KEY;
                else if (roll < 60) cmd = CMD_DEL_IDX;
                else if (roll < 78) cmd = CMD_READ;
                else if (roll < 93) cmd = roll[0] ? CMD_SORT_INS : CMD_INS_IDX;
                else                cmd = CMD_W'($urandom_range(LAST_SPARE_CMD));
            end
            // mostly in-range positions, sometimes anything the field can carry
            if ($urandom_range(99) < 15)
                pick = $urandom_range(63);
            else if (cmd == CMD_INS_IDX)
                pick = $urandom_range(n);
            else
                pick = (n > 0) ? $urandom_range(n - 1) : 0;
            if (cmd == CMD_DEL_KEY && n > 0 && $urandom_range(99) < 75)
                key = plan_shelf.slots[$urandom_range(n - 1)].key;
            else
                key = pick_key();
            queue_cmd(cmd, pick, key, $urandom, $urandom, hold);
            hold = 1'b0;
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || expected_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d commands: %0d sorted ins, %0d key del, %0d index ins, %0d index del, %0d reads",
                 n_accepted, n_by_cmd[CMD_SORT_INS], n_by_cmd[CMD_DEL_KEY],
                 n_by_cmd[CMD_INS_IDX], n_by_cmd[CMD_DEL_IDX], n_by_cmd[CMD_READ]);
        $display("statuses ok %0d, full %0d, key missing %0d, bad index %0d; deepest list %0d",
                 n_by_status[ST_OK], n_by_status[ST_FULL], n_by_status[ST_NOT_FOUND],
                 n_by_status[ST_BAD_INDEX], peak_count);
        if (n_mismatch == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog, several times the slowest expected run
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
